/* src/pdl_pkg.sv */
// ----------------------------------------------------------------------------
// pdl_pkg
// Shared types, constants and font tables for the pulse detrender and
// LED-matrix refresh block.
// ----------------------------------------------------------------------------
package pdl_pkg;

	localparam int          EWMA_SHIFT  = 5;
	localparam int          GRAPH_SHIFT = 13;
	localparam logic [15:0] DET_OFFSET  = 16'd32788;
	localparam logic [7:0]  PERIOD_RST  = 8'd10;
	localparam logic [7:0]  HR_MAX      = 8'd199;
	localparam logic [7:0]  HR_HUNDRED  = 8'd100;
	localparam logic [7:0]  HR_TWO_DIG  = 8'd99;
	localparam logic [7:0]  DIV10_MUL   = 8'd205;
	localparam int          DIV10_SHIFT = 11;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		KIND_BIG   = 2'd0,
		KIND_SMALL = 2'd1,
		KIND_ERR   = 2'd2,
		KIND_GRAPH = 2'd3
	} kind_t;

	typedef struct packed {
		logic [15:0] det;
		logic        refresh;
		kind_t       kind;
		logic [3:0]  tens;
		logic [3:0]  units;
		logic [63:0] frame;
	} job_t;

	localparam logic [63:0] GLYPH_ERROR   = 64'hF8A8883820003820;
	localparam logic [15:0] GLYPH_HUNDRED = 16'hF800;

	function automatic logic [7:0] big_col(input logic [3:0] d, input logic [1:0] c);
		logic [31:0] g;
		case (d)
			4'd0: g = 32'h7C82827C;
			4'd1: g = 32'h0042FE02;
			4'd2: g = 32'h468A9262;
			4'd3: g = 32'h4482926C;
			4'd4: g = 32'h182848FE;
			4'd5: g = 32'hE4A2A29C;
			4'd6: g = 32'h7C92924C;
			4'd7: g = 32'h808080FE;
			4'd8: g = 32'h6C92926C;
			4'd9: g = 32'h6492927C;
			default: g = 32'h0;
		endcase
		return g[31 - 8 * c -: 8];
	endfunction

	function automatic logic [7:0] small_col(input logic [3:0] d, input logic [1:0] c);
		logic [23:0] g;
		logic [7:0]  r;
		case (d)
			4'd0: g = 24'hF888F8;
			4'd1: g = 24'h00F800;
			4'd2: g = 24'hB8A8E8;
			4'd3: g = 24'h88A8F8;
			4'd4: g = 24'hE020F8;
			4'd5: g = 24'hE8A8B8;
			4'd6: g = 24'hF8A8B8;
			4'd7: g = 24'h8080F8;
			4'd8: g = 24'hF8A8F8;
			4'd9: g = 24'hE0A0F8;
			default: g = 24'h0;
		endcase
		case (c)
			2'd0: r = g[23:16];
			2'd1: r = g[15:8];
			2'd2: r = g[7:0];
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

/* src/pulse_detrend_led_matrix_display.sv */
// ----------------------------------------------------------------------------
// pulse_detrend_led_matrix_display
// Pulse sample detrender with periodic LED-matrix column refresh.
// ----------------------------------------------------------------------------
//  channel  | handshake      | payload
//  ---------+----------------+---------------------------------------------
//  input    | push / full    | sample_value, graph_mode, heart_rate
//  result   | pop / empty    | detrended, display_write, column_register,
//           |                | column_bits, last
//  config   | cfg_we         | cfg_wdata (display_period)
//
//  A sample is taken every cycle while the job queue has room; the back end
//  emits one result per cycle unless the result port stalls, so a plain sample
//  gives one result and a refresh sample eight. A result passes through
//  the job queue and the output register before it appears. Reset clears
//  baseline, scroll columns and queue; the countdown and period go to 10.
//  full rises when the four-entry queue fills behind a stalled result port.
// ----------------------------------------------------------------------------
module pulse_detrend_led_matrix_display (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  logic              push,
	output logic              full,
	input  logic [15:0]       sample_value,
	input  logic              graph_mode,
	input  logic signed [8:0] heart_rate,
	output logic              empty,
	input  logic              pop,
	output logic [15:0]       detrended,
	output logic              display_write,
	output logic [3:0]        column_register,
	output logic [7:0]        column_bits,
	output logic              last
);

	pdl_pkg::job_t new_job;
	pdl_pkg::job_t head;
	logic          accept;
	logic          q_full;
	logic          q_empty;
	logic          q_rd;

	assign full   = q_full;
	assign accept = push && !q_full;

	pdl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.accept       (accept),
		.sample_value (sample_value),
		.graph_mode   (graph_mode),
		.heart_rate   (heart_rate),
		.job          (new_job)
	);

	pdl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (accept),
		.wr_job  (new_job),
		.rd      (q_rd),
		.head    (head),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	pdl_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.q_empty         (q_empty),
		.q_rd            (q_rd),
		.pop             (pop),
		.empty           (empty),
		.detrended       (detrended),
		.display_write   (display_write),
		.column_register (column_register),
		.column_bits     (column_bits),
		.last            (last)
	);

endmodule

/* src/pdl_front.sv */
// ----------------------------------------------------------------------------
// pdl_front
// Takes samples, tracks the baseline and refresh count, scrolls the graph
// columns and classifies each transaction into a job for the back end.
// ----------------------------------------------------------------------------
module pdl_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               accept,
	input  logic [15:0]        sample_value,
	input  logic               graph_mode,
	input  logic signed [8:0]  heart_rate,
	output pdl_pkg::job_t      job
);

	logic [7:0]  period_q;
	logic [15:0] baseline_q;
	logic [7:0]  count_q;
	logic [7:0]  scroll_q [8];
	logic [7:0]  scroll_n [8];

	logic [15:0] base_n;
	logic [15:0] det;
	logic [7:0]  count_n;
	logic        refresh;
	logic        hr_err;
	logic        hr_hi;
	logic [6:0]  dval;
	logic [14:0] prod;
	logic [3:0]  tens;
	logic [6:0]  rem;

	assign base_n  = baseline_q + (sample_value >> pdl_pkg::EWMA_SHIFT)
			- (baseline_q >> pdl_pkg::EWMA_SHIFT);
	assign det     = sample_value + pdl_pkg::DET_OFFSET - base_n;
	assign count_n = count_q - 8'd1;
	assign refresh = (count_n == 8'd0);

	assign hr_err = heart_rate[8] || (heart_rate[7:0] > pdl_pkg::HR_MAX);
	assign hr_hi  = heart_rate[7:0] > pdl_pkg::HR_TWO_DIG;
	assign dval   = hr_hi ? 7'(heart_rate[7:0] - pdl_pkg::HR_HUNDRED) : heart_rate[6:0];
	assign prod   = 15'(dval) * 15'(pdl_pkg::DIV10_MUL);
	assign tens   = 4'(prod >> pdl_pkg::DIV10_SHIFT);
	assign rem    = dval - ({3'b000, tens} << 3) - ({3'b000, tens} << 1);

	always_comb begin
		for (int k = 0; k < 7; k++) begin
			scroll_n[k] = scroll_q[k + 1];
		end
		scroll_n[7] = 8'b1 << det[15:pdl_pkg::GRAPH_SHIFT];
	end

	always_comb begin
		job.det     = det;
		job.refresh = refresh;
		job.tens    = tens;
		job.units   = rem[3:0];
		if (graph_mode) begin
			job.kind = pdl_pkg::KIND_GRAPH;
		end else if (hr_err) begin
			job.kind = pdl_pkg::KIND_ERR;
		end else if (hr_hi) begin
			job.kind = pdl_pkg::KIND_SMALL;
		end else begin
			job.kind = pdl_pkg::KIND_BIG;
		end
		for (int k = 0; k < 8; k++) begin
			job.frame[8 * k +: 8] = scroll_n[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= pdl_pkg::PERIOD_RST;
			baseline_q <= '0;
			count_q    <= pdl_pkg::PERIOD_RST;
			for (int k = 0; k < 8; k++) begin
				scroll_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (accept) begin
				baseline_q <= base_n;
				count_q    <= refresh ? period_q : count_n;
				if (refresh && graph_mode) begin
					for (int k = 0; k < 8; k++) begin
						scroll_q[k] <= scroll_n[k];
					end
				end
			end
		end
	end

endmodule

/* src/pdl_queue.sv */
// ----------------------------------------------------------------------------
// pdl_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module pdl_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  pdl_pkg::job_t wr_job,
	input  logic          rd,
	output pdl_pkg::job_t head,
	output logic          q_full,
	output logic          q_empty
);

	pdl_pkg::job_t            mem_q [pdl_pkg::QDEPTH];
	logic [pdl_pkg::QAW-1:0]  wp_q;
	logic [pdl_pkg::QAW-1:0]  rp_q;
	logic [pdl_pkg::QAW:0]    cnt_q;

	assign q_full  = (cnt_q == (pdl_pkg::QAW+1)'(pdl_pkg::QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign head    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* src/pdl_back.sv */
// ----------------------------------------------------------------------------
// pdl_back
// Expands each job into one or eight results and holds them in an output
// register until popped.
// ----------------------------------------------------------------------------
module pdl_back (
	input  logic          clk,
	input  logic          arst_n,
	input  pdl_pkg::job_t head,
	input  logic          q_empty,
	output logic          q_rd,
	input  logic          pop,
	output logic          empty,
	output logic [15:0]   detrended,
	output logic          display_write,
	output logic [3:0]    column_register,
	output logic [7:0]    column_bits,
	output logic          last
);

	logic [2:0] col_q;
	logic       ovalid_q;
	logic       advance;
	logic       gen_last;
	logic [7:0] col_bits;

	always_comb begin
		case (head.kind)
			pdl_pkg::KIND_GRAPH: col_bits = head.frame[8 * col_q +: 8];
			pdl_pkg::KIND_ERR:   col_bits = pdl_pkg::GLYPH_ERROR[63 - 8 * col_q -: 8];
			pdl_pkg::KIND_BIG: begin
				if (!col_q[2]) begin
					col_bits = pdl_pkg::big_col(head.tens, col_q[1:0]);
				end else begin
					col_bits = pdl_pkg::big_col(head.units, col_q[1:0]);
				end
			end
			default: begin
				case (col_q)
					3'd0: col_bits = pdl_pkg::GLYPH_HUNDRED[15:8];
					3'd1: col_bits = pdl_pkg::GLYPH_HUNDRED[7:0];
					3'd2: col_bits = pdl_pkg::small_col(head.tens, 2'd0);
					3'd3: col_bits = pdl_pkg::small_col(head.tens, 2'd1);
					3'd4: col_bits = pdl_pkg::small_col(head.tens, 2'd2);
					3'd5: col_bits = pdl_pkg::small_col(head.units, 2'd0);
					3'd6: col_bits = pdl_pkg::small_col(head.units, 2'd1);
					default: col_bits = pdl_pkg::small_col(head.units, 2'd2);
				endcase
			end
		endcase
	end

	assign gen_last = !head.refresh || (col_q == 3'd7);
	assign advance  = !q_empty && (!ovalid_q || pop);
	assign q_rd     = advance && gen_last;
	assign empty    = !ovalid_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			detrended       <= head.det;
			display_write   <= head.refresh;
			column_register <= head.refresh ? 4'd8 - {1'b0, col_q} : 4'd0;
			column_bits     <= head.refresh ? col_bits : 8'd0;
			last            <= gen_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (advance) begin
				ovalid_q <= 1'b1;
				col_q    <= gen_last ? 3'd0 : col_q + 3'd1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

endmodule
